// ===== hw/rtl/hpack_pkg.sv =====
// Package for the HPACK Huffman encoder: payload types, the packer result
// and the static code table. No dependencies.
`timescale 1ns / 1ps

package hpack_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} hpack_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       overflow_error;
	} hpack_out_t;

	localparam int WordW = 40;  // longest padded run: 7 pending + 30 code + 3 pad

	typedef struct packed {
		logic [WordW-1:0] word;     // output bits, left aligned
		logic [2:0]       nbytes;   // full bytes in word
		logic [2:0]       rem;      // bits left pending
		logic [6:0]       pend;     // pending bits, right aligned
	} hpack_pack_t;

	localparam logic [4:0] HUFF_LEN [0:255] = '{
		5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
		5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
		5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
		5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
		5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
		5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
		5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
		5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
		5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
		5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
		5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
		5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
		5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
		5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
		5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
		5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
		5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
		5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
		5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
		5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
		5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
		5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
		5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
		5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
	};

	localparam logic [29:0] HUFF_CODE [0:255] = '{
		30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
		30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
		30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
		30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
		30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
		30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
		30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
		30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
		30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
		30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
		30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
		30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
		30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
		30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
		30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
		30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
		30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
		30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
		30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
		30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
		30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
		30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
		30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
		30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
		30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
		30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
		30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
		30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
		30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
		30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
		30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
		30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
		30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
		30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
		30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
		30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
		30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
		30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
		30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
		30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
		30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
		30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
		30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
		30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
		30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
		30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
		30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
		30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
		30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
		30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
		30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
		30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
	};

endpackage

// ===== hw/rtl/hpack_pack.sv =====
// Bit packer: appends one symbol's code to the pending bits, pads on the
// last symbol and left aligns the result. Uses hpack_pkg.
`timescale 1ns / 1ps

module hpack_pack
	import hpack_pkg::*;
(
	input  logic [7:0]  symbol,
	input  logic        last_symbol,
	input  logic [6:0]  pend,
	input  logic [2:0]  pcnt,
	output hpack_pack_t res
);

	logic [4:0]       len;
	logic [29:0]      code;
	logic [36:0]      acc;
	logic [5:0]       total;
	logic [5:0]       tp;
	logic [5:0]       sh;
	logic [WordW-1:0] ones;
	logic [WordW-1:0] fill;

	always_comb begin
		len   = HUFF_LEN[symbol];
		code  = HUFF_CODE[symbol];
		acc   = ({30'd0, pend} << len) | {7'd0, code};
		total = {3'd0, pcnt} + {1'b0, len};
		// round up to a byte boundary on the last symbol
		if (last_symbol && (total[2:0] != 3'd0)) begin
			tp = {total[5:3] + 3'd1, 3'd0};
		end else begin
			tp = total;
		end
		sh   = 6'(WordW) - total;
		ones = '1;
		fill = last_symbol ? ((ones >> total) & ~(ones >> tp)) : '0;
		res.word   = ({3'd0, acc} << sh) | fill;
		res.nbytes = tp[5:3];
		res.rem    = total[2:0];
		res.pend   = acc[6:0] & (7'h7f >> (3'd7 - total[2:0]));
	end

endmodule

// ===== hw/rtl/hpack_huffman_encoder.sv =====
// Top level of the HPACK Huffman encoder: input register, string state,
// limit check and byte serializer. Uses hpack_pkg and hpack_pack.
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data (hpack_in_t)
// out       output     out_valid / out_ready  out_data (hpack_out_t)
// cfg       input      cfg_we                 cfg_wdata (output_limit)
//
// An item is held in the input register, then is packed and its results
// loaded into a byte buffer. The buffer sends one byte per cycle while
// out_ready is high, and the next item waits until the buffer has sent
// the bytes of the last one. A new item is taken while the buffer sends its last byte.
// Reset clears string state and sets output_limit to 65535.

module hpack_huffman_encoder
	import hpack_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  hpack_in_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output hpack_out_t  out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic             v_s1;
	hpack_in_t        d_s1;
	logic [15:0]      limit_q;
	logic [6:0]       pend_q;
	logic [2:0]       pcnt_q;
	logic [15:0]      bytes_q;
	logic             abort_q;
	logic [WordW-1:0] buf_q;
	logic [2:0]       cnt_q;
	logic             err_q;
	hpack_pack_t      pk;
	logic             ld;
	logic             take;
	logic             over;

	hpack_pack u_pack (
		.symbol      (d_s1.symbol),
		.last_symbol (d_s1.last_symbol),
		.pend        (pend_q),
		.pcnt        (pcnt_q),
		.res         (pk)
	);

	assign take     = out_valid && out_ready;
	assign ld       = v_s1 && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready));
	assign in_ready = !v_s1 || ld;
	assign over     = (pk.nbytes != 3'd0)
		&& (({1'b0, bytes_q} + {14'd0, pk.nbytes}) > {1'b0, limit_q});

	assign out_valid               = cnt_q != 3'd0;
	assign out_data.out_byte       = buf_q[WordW-1 -: 8];
	assign out_data.out_last       = cnt_q == 3'd1;
	assign out_data.overflow_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			d_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'hffff;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			pcnt_q  <= '0;
			bytes_q <= '0;
			abort_q <= 1'b0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else if (ld) begin
			if (abort_q) begin
				cnt_q <= '0;
				if (d_s1.last_symbol) begin
					pend_q  <= '0;
					pcnt_q  <= '0;
					bytes_q <= '0;
					abort_q <= 1'b0;
				end
			end else if (over) begin
				// one error transfer, drop pending bits
				cnt_q   <= 3'd1;
				err_q   <= 1'b1;
				pend_q  <= '0;
				pcnt_q  <= '0;
				abort_q <= !d_s1.last_symbol;
				if (d_s1.last_symbol) begin
					bytes_q <= '0;
				end
			end else begin
				cnt_q <= pk.nbytes;
				err_q <= 1'b0;
				if (d_s1.last_symbol) begin
					pend_q  <= '0;
					pcnt_q  <= '0;
					bytes_q <= '0;
				end else begin
					pend_q  <= pk.pend;
					pcnt_q  <= pk.rem;
					bytes_q <= bytes_q + {13'd0, pk.nbytes};
				end
			end
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			buf_q <= (!abort_q && over) ? '0 : pk.word;
		end else if (take) begin
			buf_q <= buf_q << 8;
		end
	end

endmodule
